// ----- src/cursor_linked_list_engine_unit_macros.svh -----
// assertion macros used by the top level of the cursor list engine
`ifndef CURSOR_LINKED_LIST_ENGINE_UNIT_MACROS_SVH
`define CURSOR_LINKED_LIST_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CLLE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define CLLE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> cons) \
		else $error(msg);

`endif

// ----- src/clle_pkg.sv -----
// package: types, codes and defaults of the cursor list engine
`timescale 1ns / 1ps
`default_nettype none

package clle_pkg;

	localparam int SLOT_COUNT_DEF = 1024;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_NOT_USED  = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] value;
		logic [9:0]         slot;
	} item_t;

	typedef struct packed {
		logic [9:0] slot_index;
		logic [1:0] status;
	} result_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_A_SCAN,
		S_A_WR,
		S_A_LINK,
		S_S_WALK,
		S_D_CHK,
		S_D_WALK,
		S_D_FREE
	} state_t;

	typedef enum logic [2:0] {
		RD_ZERO,
		RD_INC,
		RD_HEAD,
		RD_SLOT,
		RD_NEXT
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_CUR,
		RES_SLOT
	} res_sel_t;

	// controller to datapath
	typedef struct packed {
		logic       cap;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       clr_step;
		logic       alloc;
		logic       first;
		logic       link_tail;
		logic       head_next;
		logic       clear_list;
		logic       save_link;
		logic       unlink;
		logic       tail_to_cur;
		logic       free_slot;
		logic       res_valid;
		res_sel_t   res_sel;
		logic [1:0] res_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       nonempty;
		logic       slot_in_range;
		logic       used_bit;
		logic       value_match;
		logic       cur_is_tail;
		logic       cur_is_last;
		logic       slot_is_head;
		logic       slot_is_tail;
		logic       next_is_slot;
	} stat_t;

endpackage

`default_nettype wire

// ----- src/clle_ctrl.sv -----
// controller state machine of the cursor list engine
`timescale 1ns / 1ps
`default_nettype none

module clle_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire clle_pkg::stat_t st,
	output clle_pkg::cmd_t      cmd,
	output logic                busy
);

	clle_pkg::state_t state_q;
	clle_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clle_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != clle_pkg::S_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.rd_sel     = clle_pkg::RD_ZERO;
		cmd.res_sel    = clle_pkg::RES_ZERO;
		cmd.res_status = clle_pkg::STAT_OK;
		case (state_q)
			clle_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.cur_is_last) begin
					state_d = clle_pkg::S_IDLE;
				end
			end
			clle_pkg::S_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					state_d = clle_pkg::S_DECODE;
				end
			end
			clle_pkg::S_DECODE: begin
				case (st.op)
					clle_pkg::OP_APPEND: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = clle_pkg::RD_ZERO;
						state_d    = clle_pkg::S_A_SCAN;
					end
					clle_pkg::OP_SEARCH: begin
						if (!st.nonempty) begin
							cmd.res_valid  = 1'b1;
							cmd.res_status = clle_pkg::STAT_NOT_FOUND;
							state_d        = clle_pkg::S_IDLE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = clle_pkg::RD_HEAD;
							state_d    = clle_pkg::S_S_WALK;
						end
					end
					clle_pkg::OP_DELETE: begin
						if (!st.slot_in_range || !st.nonempty) begin
							cmd.res_valid  = 1'b1;
							cmd.res_sel    = clle_pkg::RES_SLOT;
							cmd.res_status = clle_pkg::STAT_NOT_USED;
							state_d        = clle_pkg::S_IDLE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = clle_pkg::RD_SLOT;
							state_d    = clle_pkg::S_D_CHK;
						end
					end
					default: begin
						cmd.res_valid = 1'b1;
						state_d       = clle_pkg::S_IDLE;
					end
				endcase
			end
			clle_pkg::S_A_SCAN: begin
				if (!st.used_bit) begin
					state_d = clle_pkg::S_A_WR;
				end else if (st.cur_is_last) begin
					cmd.res_valid  = 1'b1;
					cmd.res_status = clle_pkg::STAT_FULL;
					state_d        = clle_pkg::S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = clle_pkg::RD_INC;
				end
			end
			clle_pkg::S_A_WR: begin
				cmd.alloc = 1'b1;
				if (st.nonempty) begin
					state_d = clle_pkg::S_A_LINK;
				end else begin
					cmd.first     = 1'b1;
					cmd.res_valid = 1'b1;
					cmd.res_sel   = clle_pkg::RES_CUR;
					state_d       = clle_pkg::S_IDLE;
				end
			end
			clle_pkg::S_A_LINK: begin
				cmd.link_tail = 1'b1;
				cmd.res_valid = 1'b1;
				cmd.res_sel   = clle_pkg::RES_CUR;
				state_d       = clle_pkg::S_IDLE;
			end
			clle_pkg::S_S_WALK: begin
				if (st.value_match) begin
					cmd.res_valid = 1'b1;
					cmd.res_sel   = clle_pkg::RES_CUR;
					state_d       = clle_pkg::S_IDLE;
				end else if (st.cur_is_tail) begin
					cmd.res_valid  = 1'b1;
					cmd.res_status = clle_pkg::STAT_NOT_FOUND;
					state_d        = clle_pkg::S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = clle_pkg::RD_NEXT;
				end
			end
			clle_pkg::S_D_CHK: begin
				if (!st.used_bit) begin
					cmd.res_valid  = 1'b1;
					cmd.res_sel    = clle_pkg::RES_SLOT;
					cmd.res_status = clle_pkg::STAT_NOT_USED;
					state_d        = clle_pkg::S_IDLE;
				end else begin
					cmd.save_link = 1'b1;
					if (st.slot_is_head) begin
						if (st.slot_is_tail) begin
							cmd.clear_list = 1'b1;
						end else begin
							cmd.head_next = 1'b1;
						end
						state_d = clle_pkg::S_D_FREE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = clle_pkg::RD_HEAD;
						state_d    = clle_pkg::S_D_WALK;
					end
				end
			end
			clle_pkg::S_D_WALK: begin
				// find the predecessor of the slot and bridge over it
				if (st.cur_is_tail) begin
					state_d = clle_pkg::S_D_FREE;
				end else if (st.next_is_slot) begin
					cmd.unlink      = 1'b1;
					cmd.tail_to_cur = st.slot_is_tail;
					state_d         = clle_pkg::S_D_FREE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = clle_pkg::RD_NEXT;
				end
			end
			clle_pkg::S_D_FREE: begin
				cmd.free_slot = 1'b1;
				cmd.res_valid = 1'b1;
				cmd.res_sel   = clle_pkg::RES_SLOT;
				state_d       = clle_pkg::S_IDLE;
			end
			default: begin
				state_d = clle_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/clle_dpath.sv -----
// datapath of the cursor list engine: slot store, list ends, walk cursor, result
`timescale 1ns / 1ps
`default_nettype none

module clle_dpath #(
	parameter int SLOT_COUNT = clle_pkg::SLOT_COUNT_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire clle_pkg::item_t item,
	input  wire clle_pkg::cmd_t  cmd,
	output clle_pkg::stat_t      st,
	output clle_pkg::result_t    result,
	output logic                 done
);

	localparam int IW = $clog2(SLOT_COUNT);

	logic [31:0]   value_mem [SLOT_COUNT];
	logic [IW-1:0] next_mem  [SLOT_COUNT];
	logic          used_mem  [SLOT_COUNT];

	logic [1:0]    op_q;
	logic [31:0]   value_q;
	logic [9:0]    slot_q;

	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic          nonempty_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] link_q;

	logic [31:0]   value_rd_q;
	logic [IW-1:0] next_rd_q;
	logic          used_rd_q;

	clle_pkg::result_t res_q;
	logic              done_q;

	logic [IW-1:0] slot_ix;
	logic [IW-1:0] rd_addr;

	logic          next_we;
	logic [IW-1:0] next_wa;
	logic [IW-1:0] next_wd;
	logic          used_we;
	logic [IW-1:0] used_wa;
	logic          used_wd;

	assign slot_ix = IW'(slot_q);

	always_comb begin
		case (cmd.rd_sel)
			clle_pkg::RD_ZERO: rd_addr = '0;
			clle_pkg::RD_INC:  rd_addr = cur_q + IW'(1);
			clle_pkg::RD_HEAD: rd_addr = head_q;
			clle_pkg::RD_SLOT: rd_addr = slot_ix;
			clle_pkg::RD_NEXT: rd_addr = next_rd_q;
			default:           rd_addr = '0;
		endcase
	end

	// one writer of the link store per cycle
	always_comb begin
		next_we = 1'b0;
		next_wa = cur_q;
		next_wd = '0;
		if (cmd.alloc) begin
			next_we = 1'b1;
		end else if (cmd.link_tail) begin
			next_we = 1'b1;
			next_wa = tail_q;
			next_wd = cur_q;
		end else if (cmd.unlink) begin
			next_we = 1'b1;
			next_wd = link_q;
		end
	end

	always_comb begin
		used_we = 1'b0;
		used_wa = cur_q;
		used_wd = 1'b0;
		if (cmd.clr_step) begin
			used_we = 1'b1;
		end else if (cmd.alloc) begin
			used_we = 1'b1;
			used_wd = 1'b1;
		end else if (cmd.free_slot) begin
			used_we = 1'b1;
			used_wa = slot_ix;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			value_mem[cur_q] <= value_q;
		end
		if (cmd.rd_en) begin
			value_rd_q <= value_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (cmd.rd_en) begin
			next_rd_q <= next_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[used_wa] <= used_wd;
		end
		if (cmd.rd_en) begin
			used_rd_q <= used_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q    <= item.op;
			value_q <= item.value;
			slot_q  <= item.slot;
		end
		if (cmd.save_link) begin
			link_q <= next_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			nonempty_q <= 1'b0;
			cur_q      <= '0;
		end else begin
			if (cmd.clr_step) begin
				cur_q <= cur_q + IW'(1);
			end else if (cmd.rd_en) begin
				cur_q <= rd_addr;
			end
			if (cmd.first) begin
				head_q     <= cur_q;
				tail_q     <= cur_q;
				nonempty_q <= 1'b1;
			end
			if (cmd.link_tail || cmd.tail_to_cur) begin
				tail_q <= cur_q;
			end
			if (cmd.head_next) begin
				head_q <= next_rd_q;
			end
			if (cmd.clear_list) begin
				nonempty_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_valid) begin
			res_q.status <= cmd.res_status;
			case (cmd.res_sel)
				clle_pkg::RES_CUR:  res_q.slot_index <= 10'(cur_q);
				clle_pkg::RES_SLOT: res_q.slot_index <= slot_q;
				default:            res_q.slot_index <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_valid;
		end
	end

	assign result = res_q;
	assign done   = done_q;

	always_comb begin
		st               = '0;
		st.op            = op_q;
		st.nonempty      = nonempty_q;
		st.slot_in_range = (32'(slot_q) < 32'(SLOT_COUNT));
		st.used_bit      = used_rd_q;
		st.value_match   = (value_rd_q == value_q);
		st.cur_is_tail   = (cur_q == tail_q);
		st.cur_is_last   = (cur_q == IW'(SLOT_COUNT - 1));
		st.slot_is_head  = (slot_ix == head_q);
		st.slot_is_tail  = (slot_ix == tail_q);
		st.next_is_slot  = (next_rd_q == slot_ix);
	end

endmodule

`default_nettype wire

// ----- src/cursor_linked_list_engine_unit.sv -----
// top level of the cursor list engine: controller plus datapath
//
//  channel  | ports                  | beat taken when
//  ---------+------------------------+------------------------------
//  item     | start, busy, item      | start high and busy low
//  result   | done, result           | done high, held for one cycle
//
// append scans upward from slot zero for a free slot, fills it and links it
// behind the tail; search walks the list from the head; delete checks the slot
// and, unless it is the head, walks to its predecessor. the walks run one slot
// a cycle through the single read port of the slot store. a result shows on the
// cycle after the last work cycle, and busy is already low then. after reset a
// clearing pass over every slot runs with busy high. the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "cursor_linked_list_engine_unit_macros.svh"

module cursor_linked_list_engine_unit #(
	parameter int SLOT_COUNT = clle_pkg::SLOT_COUNT_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire clle_pkg::item_t item,
	output logic                 done,
	output clle_pkg::result_t    result
);

	clle_pkg::cmd_t  cmd;
	clle_pkg::stat_t st;

	clle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	clle_dpath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.st     (st),
		.result (result),
		.done   (done)
	);

	// an unused op code is answered straight from the decode state after its beat
	`CLLE_ASSERT_NXT(a_unused_op, clk, arst_n, start && !busy && (item.op == clle_pkg::OP_UNUSED), ##1 done, "unused op gave no result")

	// no store or list change while waiting for a beat
	`CLLE_ASSERT_IMP(a_idle_quiet, clk, arst_n, !busy, !(cmd.alloc || cmd.link_tail || cmd.unlink || cmd.free_slot || cmd.clr_step), "store written while idle")

	// a full store reports slot zero
	`CLLE_ASSERT_IMP(a_full_zero, clk, arst_n, done && (result.status == clle_pkg::STAT_FULL), result.slot_index == 10'd0, "full result with nonzero slot")

	// a result always closes work that kept the block busy
	`CLLE_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy) && !busy, "result without preceding work")

endmodule

`default_nettype wire

// ----- sim/clle_checker.sv -----
// checker for the cursor list engine: mirrors the slot store and compares each result beat
`timescale 1ns / 1ps

module clle_checker #(
	parameter int SLOT_COUNT = clle_pkg::SLOT_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  clle_pkg::item_t   item,
	input  logic              done,
	input  clle_pkg::result_t result,
	output int                mismatch_count,
	output int                outcomes_pending,
	output int                outcomes_checked
);

	// mirror of the slot store and the chain ends
	bit [31:0] node_val  [SLOT_COUNT];
	bit [9:0]  node_link [SLOT_COUNT];
	bit        node_live [SLOT_COUNT];
	int        head_at = 0;
	int        tail_at = 0;
	bit        chain_nonempty = 1'b0;

	clle_pkg::result_t awaited_outcomes [$];
	clle_pkg::result_t want;
	int        mism = 0;
	int        pend = 0;
	int        seen = 0;

	assign mismatch_count   = mism;
	assign outcomes_pending = pend;
	assign outcomes_checked = seen;

	task automatic apply_list_op(input clle_pkg::item_t it, output clle_pkg::result_t r);
		int s;
		int cur;
		int n;
		r.slot_index = '0;
		r.status     = clle_pkg::STAT_OK;
		case (it.op)
			clle_pkg::OP_APPEND: begin
				s = 0;
				while (s < SLOT_COUNT && node_live[s])
					s++;
				if (s >= SLOT_COUNT) begin
					r.status = clle_pkg::STAT_FULL;
				end else begin
					node_val[s]  = it.value;
					node_link[s] = '0;
					node_live[s] = 1'b1;
					if (!chain_nonempty) begin
						head_at        = s;
						chain_nonempty = 1'b1;
					end else begin
						node_link[tail_at] = 10'(s);
					end
					tail_at      = s;
					r.slot_index = 10'(s);
				end
			end
			clle_pkg::OP_SEARCH: begin
				r.status = clle_pkg::STAT_NOT_FOUND;
				if (chain_nonempty) begin
					cur = head_at;
					for (n = 0; n < SLOT_COUNT; n++) begin
						if (node_val[cur] == it.value) begin
							r.slot_index = 10'(cur);
							r.status     = clle_pkg::STAT_OK;
							break;
						end
						if (cur == tail_at)
							break;
						cur = int'(node_link[cur]);
					end
				end
			end
			clle_pkg::OP_DELETE: begin
				s            = int'(it.slot);
				r.slot_index = it.slot;
				if (s >= SLOT_COUNT || !node_live[s] || !chain_nonempty) begin
					r.status = clle_pkg::STAT_NOT_USED;
				end else begin
					if (s == head_at) begin
						if (s == tail_at)
							chain_nonempty = 1'b0;
						else
							head_at = int'(node_link[s]);
					end else begin
						// find the predecessor and splice around the slot
						cur = head_at;
						for (n = 0; n < SLOT_COUNT; n++) begin
							if (cur == tail_at)
								break;
							if (node_link[cur] == 10'(s)) begin
								node_link[cur] = node_link[s];
								if (s == tail_at)
									tail_at = cur;
								break;
							end
							cur = int'(node_link[cur]);
						end
					end
					node_live[s] = 1'b0;
				end
			end
			default: begin
				r.status = clle_pkg::STAT_OK;
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (awaited_outcomes.size() == 0) begin
					$error("result beat with no item outstanding: slot_index %0d status %0d",
						result.slot_index, result.status);
					mism++;
				end else begin
					want = awaited_outcomes.pop_front();
					if (result.slot_index !== want.slot_index) begin
						$error("slot_index: expected %0d, got %0d", want.slot_index,
							result.slot_index);
						mism++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						mism++;
					end
					seen++;
				end
			end
			if (start && !busy) begin
				apply_list_op(item, want);
				awaited_outcomes.push_back(want);
			end
			pend = awaited_outcomes.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
// testbench top: drives list commands into the cursor list engine and reports the verdict
`timescale 1ns / 1ps

module tb;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	clle_pkg::item_t   item;
	logic              done;
	clle_pkg::result_t result;

	int mismatch_count;
	int outcomes_pending;
	int outcomes_checked;

	int          n_append = 0;
	int          n_search = 0;
	int          n_delete = 0;
	int          n_other  = 0;
	bit          quiet_run = 1'b0;
	logic [31:0] recent_values [$];
	logic [31:0] last_fill_value;
	int          k;
	int          r;
	int          leftover;

	cursor_linked_list_engine_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	clle_checker CHK (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.item             (item),
		.done             (done),
		.result           (result),
		.mismatch_count   (mismatch_count),
		.outcomes_pending (outcomes_pending),
		.outcomes_checked (outcomes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic clle_pkg::item_t mk(logic [1:0] op, logic [31:0] value, logic [9:0] slot);
		clle_pkg::item_t it;
		it.op    = op;
		it.value = value;
		it.slot  = slot;
		return it;
	endfunction

	function automatic int pick_gap();
		int p;
		if (quiet_run)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_item(input clle_pkg::item_t it);
		start <= 1'b1;
		item  <= it;
		while (busy)
			@(negedge clk);
		@(negedge clk);
		case (it.op)
			clle_pkg::OP_APPEND: n_append++;
			clle_pkg::OP_SEARCH: n_search++;
			clle_pkg::OP_DELETE: n_delete++;
			default:             n_other++;
		endcase
		if (it.op == clle_pkg::OP_APPEND) begin
			recent_values.push_back(it.value);
			if (recent_values.size() > 64)
				void'(recent_values.pop_front());
		end
	endtask

	task automatic send_gapped(input clle_pkg::item_t it);
		int g;
		send_item(it);
		g = pick_gap();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic drain();
		int w;
		start <= 1'b0;
		@(negedge clk);
		for (w = 0; w < 4096 && outcomes_pending != 0; w++)
			@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		int p;
		p = $urandom_range(0, 99);
		if (p < 15 && recent_values.size() > 0)
			return recent_values[$urandom_range(0, recent_values.size() - 1)];
		if (p < 30)
			return 32'($urandom_range(0, 15));
		if (p < 34)
			return 32'h8000_0000;
		if (p < 38)
			return 32'h7fff_ffff;
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_search_value();
		if ($urandom_range(0, 99) < 70 && recent_values.size() > 0)
			return recent_values[$urandom_range(0, recent_values.size() - 1)];
		return pick_value();
	endfunction

	function automatic logic [9:0] pick_slot();
		if ($urandom_range(0, 99) < 85)
			return 10'($urandom_range(0, 47));
		return 10'($urandom_range(0, 1023));
	endfunction

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty list, sole element, duplicates, head/middle/tail removal
		send_gapped(mk(clle_pkg::OP_SEARCH, 32'h0000_0000, 10'd0));
		send_gapped(mk(clle_pkg::OP_DELETE, 32'hffff_ffff, 10'd0));
		send_gapped(mk(clle_pkg::OP_UNUSED, 32'hffff_ffff, 10'h3ff));
		send_gapped(mk(clle_pkg::OP_APPEND, 32'h7fff_ffff, 10'h3ff));
		send_gapped(mk(clle_pkg::OP_DELETE, 32'h0000_0000, 10'd0));
		send_gapped(mk(clle_pkg::OP_SEARCH, 32'h7fff_ffff, 10'd0));
		send_gapped(mk(clle_pkg::OP_APPEND, 32'h8000_0000, 10'd0));
		send_gapped(mk(clle_pkg::OP_APPEND, 32'hffff_ffff, 10'd0));
		send_gapped(mk(clle_pkg::OP_APPEND, 32'h0000_0000, 10'd0));
		send_gapped(mk(clle_pkg::OP_APPEND, 32'hffff_ffff, 10'd0));
		send_gapped(mk(clle_pkg::OP_SEARCH, 32'hffff_ffff, 10'd0));
		send_gapped(mk(clle_pkg::OP_SEARCH, 32'h0000_0000, 10'h3ff));
		send_gapped(mk(clle_pkg::OP_DELETE, 32'h0000_0000, 10'h3ff));
		send_gapped(mk(clle_pkg::OP_DELETE, 32'h0000_0000, 10'd3));
		send_gapped(mk(clle_pkg::OP_APPEND, 32'd5, 10'd0));
		send_gapped(mk(clle_pkg::OP_DELETE, 32'h0000_0000, 10'd0));
		send_gapped(mk(clle_pkg::OP_DELETE, 32'h0000_0000, 10'd2));
		send_gapped(mk(clle_pkg::OP_SEARCH, 32'h8000_0000, 10'd0));
		send_gapped(mk(clle_pkg::OP_SEARCH, 32'd5, 10'd0));
		send_gapped(mk(clle_pkg::OP_APPEND, 32'h1234_5678, 10'd0));
		send_gapped(mk(clle_pkg::OP_SEARCH, 32'h1234_5678, 10'd0));
		send_gapped(mk(clle_pkg::OP_UNUSED, $urandom, 10'($urandom_range(0, 1023))));
		send_gapped(mk(clle_pkg::OP_DELETE, 32'h0000_0000, 10'd2));
		drain();

		// random mix that keeps the chain a few dozen nodes long
		for (k = 0; k < 534; k++) begin
			if ($urandom_range(0, 39) == 0)
				quiet_run = ~quiet_run;
			if ($urandom_range(0, 99) < 3)
				drain();
			r = $urandom_range(0, 99);
			if (r < 33)
				send_gapped(mk(clle_pkg::OP_APPEND, pick_value(),
					10'($urandom_range(0, 1023))));
			else if (r < 63)
				send_gapped(mk(clle_pkg::OP_SEARCH, pick_search_value(),
					10'($urandom_range(0, 1023))));
			else if (r < 97)
				send_gapped(mk(clle_pkg::OP_DELETE, $urandom, pick_slot()));
			else
				send_gapped(mk(clle_pkg::OP_UNUSED, $urandom, 10'($urandom_range(0, 1023))));
		end
		quiet_run = 1'b0;
		drain();

		// a short run of appends, then searches for the tail value, deletes and more appends
		for (k = 0; k < 12; k++) begin
			last_fill_value = $urandom;
			send_gapped(mk(clle_pkg::OP_APPEND, last_fill_value,
				10'($urandom_range(0, 1023))));
		end
		send_gapped(mk(clle_pkg::OP_SEARCH, $urandom, 10'd0));
		send_gapped(mk(clle_pkg::OP_SEARCH, last_fill_value, 10'd0));
		send_gapped(mk(clle_pkg::OP_DELETE, 32'h0000_0000, 10'h3ff));
		send_gapped(mk(clle_pkg::OP_DELETE, 32'h0000_0000, 10'd500));
		send_gapped(mk(clle_pkg::OP_DELETE, 32'h0000_0000, 10'd0));
		send_gapped(mk(clle_pkg::OP_SEARCH, last_fill_value, 10'd0));
		send_gapped(mk(clle_pkg::OP_APPEND, $urandom, 10'd0));
		send_gapped(mk(clle_pkg::OP_APPEND, $urandom, 10'd0));
		send_gapped(mk(clle_pkg::OP_APPEND, $urandom, 10'd0));
		send_gapped(mk(clle_pkg::OP_APPEND, $urandom, 10'd0));
		send_gapped(mk(clle_pkg::OP_UNUSED, 32'hffff_ffff, 10'h3ff));
		drain();
		repeat (16) @(negedge clk);

		leftover = outcomes_pending;
		if (leftover != 0)
			$error("%0d results never arrived", leftover);
		$display("covered %0d appends, %0d searches, %0d deletes, %0d unused-op items",
			n_append, n_search, n_delete, n_other);
		$display("%0d result beats checked on empty, single-node and few-dozen-node chains",
			outcomes_checked);
		if (mismatch_count == 0 && leftover == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/clle_pkg.sv
src/clle_ctrl.sv
src/clle_dpath.sv
src/cursor_linked_list_engine_unit.sv
sim/clle_checker.sv
sim/tb.sv
